// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cipher block; empty when SYNTH
// is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/fbc_pkg.sv
// ---------------------------------------------------------------------------
// fbc_pkg
// Types, register indexes and round function of the Feistel bitslice cipher.
// ---------------------------------------------------------------------------
package fbc_pkg;

	localparam int KEY_WORDS = 7;
	localparam int KEY_BITS  = KEY_WORDS * 64;

	localparam logic [2:0] REG_ROUND_COUNT = 3'd0;
	localparam logic [2:0] REG_KEY_WORD_0  = 3'd1;

	localparam logic [3:0] ROUND_COUNT_RESET = 4'd12;

	typedef struct packed {
		logic        valid;
		logic [3:0]  rounds;
		logic [63:0] block;
	} fbc_stage_t;

	function automatic logic [31:0] s_layer(input logic [31:0] x);
		logic [7:0] d0, d1, d2, d3;
		d0 = x[31:24];
		d1 = x[23:16];
		d2 = x[15:8];
		d3 = x[7:0];
		d2 = d2 ^ ~(d0 | d1);
		d3 = d3 ^ (~d1 & d2);
		d0 = d0 ^ ~(d2 & d3);
		d1 = d1 ^ (~d0 | d3);
		return {d0, d1, d2, d3};
	endfunction

	function automatic logic [7:0] lin_map(input logic [7:0] x);
		return x ^ {x[6:0], x[7]} ^ {x[0], x[7:1]};
	endfunction

	function automatic logic [31:0] round_f(input logic [31:0] d_in, input logic [95:0] k);
		logic [31:0] d;
		d = d_in;
		for (int p = 0; p < 3; p++) begin
			d = s_layer(d);
			d = {lin_map(d[31:24]), lin_map(d[23:16]), lin_map(d[15:8]), lin_map(d[7:0])};
			d = d ^ k[95 - 32 * p -: 32];
		end
		return s_layer(d);
	endfunction

endpackage

// File: rtl/feistel_bitslice_cipher_64_unit.sv
// ---------------------------------------------------------------------------
// feistel_bitslice_cipher_64_unit
// 64-bit Feistel block cipher with a settable round count, one registered
// stage per round.
// ---------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     start, busy          plain_block
//  result    done (strobe)        cipher_block
//  config    cfg_wr_en            cfg_index, cfg_wdata
//
// Each item passes from start to done through one register stage per
// Feistel round, and a new item may start in every cycle.
// Reset clears all valid bits, sets round_count to 12 and clears the key.
// busy never rises: nothing downstream can hold a result back, so the
// pipeline never stalls.
module feistel_bitslice_cipher_64_unit #(
	parameter int MAX_ROUNDS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] plain_block,
	output logic        done,
	output logic [63:0] cipher_block,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	`include "assert_macros.svh"

	logic [3:0]                    round_count_q;
	logic [63:0]                   key_q [fbc_pkg::KEY_WORDS];
	logic [fbc_pkg::KEY_BITS-1:0]  key_flat;
	logic [3:0]                    rounds_eff;
	fbc_pkg::fbc_stage_t           stage [MAX_ROUNDS + 1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q <= fbc_pkg::ROUND_COUNT_RESET;
			for (int w = 0; w < fbc_pkg::KEY_WORDS; w++) begin
				key_q[w] <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == fbc_pkg::REG_ROUND_COUNT) begin
				round_count_q <= cfg_wdata[3:0];
			end else begin
				key_q[cfg_index - fbc_pkg::REG_KEY_WORD_0] <= cfg_wdata;
			end
		end
	end

	always_comb begin
		for (int w = 0; w < fbc_pkg::KEY_WORDS; w++) begin
			key_flat[fbc_pkg::KEY_BITS - 1 - 64 * w -: 64] = key_q[w];
		end
	end

	assign rounds_eff = (round_count_q > 4'(MAX_ROUNDS)) ? 4'(MAX_ROUNDS) : round_count_q;

	assign busy     = 1'b0;
	assign stage[0] = '{valid: start, rounds: rounds_eff, block: plain_block};

	for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_round
		fbc_round #(
			.ROUND_IDX(i)
		) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.stage_in (stage[i]),
			.round_key(key_flat[fbc_pkg::KEY_BITS - 1 - 32 * i -: 96]),
			.stage_out(stage[i + 1])
		);
	end

	assign done         = stage[MAX_ROUNDS].valid;
	assign cipher_block = stage[MAX_ROUNDS].block;

	`ASSERT_NEXT(a_first_to_done, clk, arst_n, start && MAX_ROUNDS == 1, done)
	`ASSERT_NEXT(a_stage_chain, clk, arst_n, stage[1].valid && MAX_ROUNDS > 1, stage[2 % (MAX_ROUNDS + 1)].valid)
	`ASSERT_IMPLIES(a_rounds_sat, clk, arst_n, stage[1].valid, stage[1].rounds <= 4'(MAX_ROUNDS))
	`ASSERT_NEXT(a_rc_write, clk, arst_n, cfg_wr_en && cfg_index == fbc_pkg::REG_ROUND_COUNT, round_count_q == $past(cfg_wdata[3:0]))

endmodule

// File: rtl/fbc_round.sv
// ---------------------------------------------------------------------------
// fbc_round
// One registered Feistel round; applied only when the item's round count
// reaches this stage, otherwise the block passes through.
// ---------------------------------------------------------------------------
module fbc_round #(
	parameter int ROUND_IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fbc_pkg::fbc_stage_t stage_in,
	input  logic [95:0]        round_key,
	output fbc_pkg::fbc_stage_t stage_out
);

	logic        apply;
	logic [31:0] half_l;
	logic [31:0] half_r;
	logic [63:0] block_next;
	logic        valid_s1;
	logic [3:0]  rounds_s1;
	logic [63:0] block_s1;

	assign half_l = stage_in.block[63:32];
	assign half_r = stage_in.block[31:0];
	assign apply  = stage_in.rounds > 4'(ROUND_IDX);

	always_comb begin
		if (apply) begin
			block_next = {fbc_pkg::round_f(half_l, round_key) ^ half_r, half_l};
		end else begin
			block_next = stage_in.block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= stage_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		rounds_s1 <= stage_in.rounds;
		block_s1  <= block_next;
	end

	assign stage_out = '{valid: valid_s1, rounds: rounds_s1, block: block_s1};

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for feistel_bitslice_cipher_64_unit. A driver feeds
// plaintext items, register writes and drain points from a queue. A monitor
// keeps its own copy of the round count and the key, predicts each
// ciphertext as an item is accepted, and checks every done strobe in order.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ROUNDS  = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int KEY_WORDS   = fbc_pkg::KEY_WORDS;
	localparam int KEY_BITS    = fbc_pkg::KEY_BITS;

	typedef enum logic [1:0] {
		JOB_BLOCK,
		JOB_WRITE,
		JOB_DRAIN
	} job_kind_t;

	typedef struct {
		job_kind_t   kind;
		logic [2:0]  index;
		logic [63:0] data;
		logic        gap_ok;
	} job_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        busy;
	logic [63:0] plain_block = '0;
	logic        done;
	logic [63:0] cipher_block;
	logic        cfg_wr_en   = 1'b0;
	logic [2:0]  cfg_index   = '0;
	logic [63:0] cfg_wdata   = '0;

	job_t              job_q[$];
	logic [63:0]       cipher_q[$];
	logic [3:0]        model_rounds;
	logic [KEY_BITS-1:0] model_key;
	int                errors = 0;
	int                cycles = 0;

	feistel_bitslice_cipher_64_unit #(
		.MAX_ROUNDS(MAX_ROUNDS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.plain_block (plain_block),
		.done        (done),
		.cipher_block(cipher_block),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] slice_sbox(input logic [31:0] x);
		logic [7:0] s[4];
		for (int j = 0; j < 4; j++) s[j] = x[31 - 8 * j -: 8];
		s[2] = s[2] ^ ~(s[0] | s[1]);
		s[3] = s[3] ^ (~s[1] & s[2]);
		s[0] = s[0] ^ ~(s[2] & s[3]);
		s[1] = s[1] ^ (~s[0] | s[3]);
		return {s[0], s[1], s[2], s[3]};
	endfunction

	function automatic logic [7:0] spread_byte(input logic [7:0] x);
		return x ^ {x[6:0], x[7]} ^ {x[0], x[7:1]};
	endfunction

	function automatic logic [31:0] half_mix(input logic [31:0] half, input int kb,
			input logic [KEY_BITS-1:0] key);
		logic [31:0] d;
		int          k;
		d = half;
		for (int p = 0; p < 3; p++) begin
			d = slice_sbox(d);
			for (int j = 0; j < 4; j++) d[31 - 8 * j -: 8] = spread_byte(d[31 - 8 * j -: 8]);
			k = kb + 4 * p;
			d = d ^ key[KEY_BITS - 1 - 8 * k -: 32];
		end
		return slice_sbox(d);
	endfunction

	function automatic logic [63:0] encrypt_block(input logic [63:0] blk,
			input logic [3:0] rc, input logic [KEY_BITS-1:0] key);
		logic [31:0] l, r, t;
		int          n;
		{l, r} = blk;
		n = (int'(rc) > MAX_ROUNDS) ? MAX_ROUNDS : int'(rc);
		for (int i = 0; i < n; i++) begin
			t = l;
			l = half_mix(l, 4 * i, key) ^ r;
			r = t;
		end
		return {l, r};
	endfunction

	task automatic add_block(input logic [63:0] data, input logic gap_ok);
		job_t j;
		j.kind = JOB_BLOCK;
		j.index = '0;
		j.data = data;
		j.gap_ok = gap_ok;
		job_q.push_back(j);
	endtask

	task automatic add_write(input logic [2:0] index, input logic [63:0] data);
		job_t j;
		j.kind = JOB_WRITE;
		j.index = index;
		j.data = data;
		j.gap_ok = 1'b1;
		job_q.push_back(j);
	endtask

	task automatic add_drain();
		job_t j;
		j.kind = JOB_DRAIN;
		j.index = '0;
		j.data = '0;
		j.gap_ok = 1'b1;
		job_q.push_back(j);
	endtask

	always @(posedge clk or negedge arst_n) begin
		job_t job;
		logic go;
		logic wr;
		if (!arst_n) begin
			start <= 1'b0;
			plain_block <= '0;
			cfg_wr_en <= 1'b0;
			cfg_index <= '0;
			cfg_wdata <= '0;
		end else begin
			go = 1'b0;
			wr = 1'b0;
			if (start && busy) begin
				go = 1'b1;
			end else if (job_q.size() != 0) begin
				job = job_q[0];
				case (job.kind)
					JOB_BLOCK: begin
						if (!job.gap_ok || $urandom_range(99) >= 28) begin
							go = 1'b1;
							plain_block <= job.data;
							job_q.delete(0);
						end
					end
					JOB_WRITE: begin
						if (!start && cipher_q.size() == 0) begin
							wr = 1'b1;
							cfg_index <= job.index;
							cfg_wdata <= job.data;
							job_q.delete(0);
						end
					end
					JOB_DRAIN: begin
						if (!start && cipher_q.size() == 0) job_q.delete(0);
					end
					default: begin
						job_q.delete(0);
					end
				endcase
				if (!go) plain_block <= rand64();
			end
			start <= go;
			cfg_wr_en <= wr;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		int          widx;
		if (!arst_n) begin
			model_rounds = fbc_pkg::ROUND_COUNT_RESET;
			model_key = '0;
			cipher_q.delete();
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == fbc_pkg::REG_ROUND_COUNT) begin
					model_rounds = cfg_wdata[3:0];
				end else begin
					widx = int'(cfg_index) - int'(fbc_pkg::REG_KEY_WORD_0);
					model_key[KEY_BITS - 1 - 64 * widx -: 64] = cfg_wdata;
				end
			end
			if (start && !busy)
				cipher_q.push_back(encrypt_block(plain_block, model_rounds, model_key));
			if (done === 1'b1) begin
				if (cipher_q.size() == 0) begin
					$display("%0t cipher_block unexpected: expected none, actual %h",
						$time, cipher_block);
					errors++;
				end else begin
					want = cipher_q.pop_front();
					if (cipher_block !== want) begin
						$display("%0t cipher_block mismatch: expected %h, actual %h",
							$time, want, cipher_block);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, cipher_q.size());
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		logic [63:0] v;
		logic [3:0]  rc;
		int          pick;

		// Reset values: twelve rounds, zero key.
		add_block(64'h0, 1'b1);
		add_block('1, 1'b1);
		add_block(64'h0123_4567_89ab_cdef, 1'b1);
		for (int w = 0; w < KEY_WORDS; w++) begin
			add_write(3'(int'(fbc_pkg::REG_KEY_WORD_0) + w), '1);
		end
		add_block(64'h0, 1'b1);
		add_block('1, 1'b1);
		// Zero rounds pass the block through.
		add_write(fbc_pkg::REG_ROUND_COUNT, 64'h0);
		add_block(64'h0, 1'b1);
		add_block('1, 1'b1);
		add_block(64'ha5a5_5a5a_0ff0_f00f, 1'b1);
		add_write(fbc_pkg::REG_ROUND_COUNT, 64'h1);
		add_block(64'h8000_0000_0000_0000, 1'b1);
		add_block(64'h0000_0000_0000_0001, 1'b1);
		// Counts above the maximum saturate; upper data bits are ignored.
		add_write(fbc_pkg::REG_ROUND_COUNT, 64'hffff_ffff_ffff_fffd);
		add_block(64'h0, 1'b1);
		add_block(64'hdead_beef_0bad_f00d, 1'b1);
		add_write(fbc_pkg::REG_ROUND_COUNT, 64'h0000_0000_0000_000f);
		add_block('1, 1'b1);
		add_block(64'h0, 1'b1);
		add_write(fbc_pkg::REG_ROUND_COUNT, 64'hc);
		for (int w = 0; w < KEY_WORDS; w++) begin
			add_write(3'(int'(fbc_pkg::REG_KEY_WORD_0) + w), rand64());
		end
		add_block(rand64(), 1'b1);
		add_block(rand64(), 1'b1);
		add_block(64'h7fff_ffff_ffff_ffff, 1'b1);

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: rc = 4'd0;
				1: rc = 4'd12;
				2: rc = 4'd15;
				3: rc = 4'd1;
				default: rc = 4'($urandom_range(15));
			endcase
			v = rand64();
			v[3:0] = rc;
			add_write(fbc_pkg::REG_ROUND_COUNT, v);
			for (int w = 0; w < KEY_WORDS; w++) begin
				if (ph == 0 || $urandom_range(99) < 70) begin
					pick = $urandom_range(7);
					if (pick == 0) v = '0;
					else if (pick == 1) v = '1;
					else v = rand64();
					add_write(3'(int'(fbc_pkg::REG_KEY_WORD_0) + w), v);
				end
			end
			for (int n = 0; n < 125; n++) begin
				pick = $urandom_range(99);
				if (pick < 3) v = '0;
				else if (pick < 6) v = '1;
				else v = rand64();
				add_block(v, ph != 4);
				if (n == 60 || $urandom_range(99) < 2) add_drain();
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (job_q.size() != 0 || start || cipher_q.size() != 0) @(posedge clk);
		repeat (2 * MAX_ROUNDS + 8) @(posedge clk);

		if (cipher_q.size() != 0)
			$display("%0t %0d results missing, oldest expected %h, actual none",
				$time, cipher_q.size(), cipher_q[0]);
		if (errors == 0 && cipher_q.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
